// ----- rtl/sbto_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbto_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 240;
    localparam int MAX_CHARS     = 16;

    localparam int GLYPH_W    = 5;
    localparam int GLYPH_H    = 7;
    localparam int GLYPH_STEP = 6;
    localparam int SCALE_MAX  = 15;

    // line buffer index and position counter widths
    localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int POS_W = $clog2(MAX_CHARS + 1);

    // nonnegative offset from the origin: 8-bit pixel minus 10-bit signed origin
    localparam int COORD_W = 10;
    localparam int THR_RAW = $clog2(MAX_CHARS * GLYPH_STEP * SCALE_MAX + 1);
    localparam int THR_W   = (THR_RAW > COORD_W) ? THR_RAW : COORD_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register indexes, byte address is four times the index
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_SCALE      = 3'd2;
    localparam logic [2:0] REG_TEXT_COLOR = 3'd3;
    localparam logic [2:0] REG_BACK_COLOR = 3'd4;
    localparam logic [2:0] REG_TEXT_LEN   = 3'd5;

    localparam logic [3:0] SLOT_BLANK = 4'd15;

    typedef struct packed {
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [3:0]  scale;
        logic [15:0] text_color;
        logic [15:0] background_color;
        logic [4:0]  text_length;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic [3:0]         char_index;
        logic [7:0]         char_code;
        logic               kill;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } q_entry_t;

    typedef struct packed {
        logic q_valid;
        logic q_pop;
        logic out_load;
    } back_stat_t;

    function automatic logic [3:0] glyph_slot(input logic [7:0] code);
        logic [3:0] slot;
        unique case (code)
            8'h28:   slot = 4'd0;   // (
            8'h29:   slot = 4'd1;   // )
            8'h43:   slot = 4'd2;   // C
            8'h45:   slot = 4'd3;   // E
            8'h4C:   slot = 4'd4;   // L
            8'h4F:   slot = 4'd5;   // O
            8'h52:   slot = 4'd6;   // R
            8'h5F:   slot = 4'd7;   // _
            8'h61:   slot = 4'd8;   // a
            8'h64:   slot = 4'd9;   // d
            8'h67:   slot = 4'd10;  // g
            8'h69:   slot = 4'd11;  // i
            8'h6E:   slot = 4'd12;  // n
            8'h6F:   slot = 4'd13;  // o
            8'h2E:   slot = 4'd14;  // full stop
            default: slot = SLOT_BLANK;
        endcase
        return slot;
    endfunction

    // one glyph row, bit 4 is the leftmost column; rows packed top row in the msbs
    function automatic logic [GLYPH_W-1:0] font_row(input logic [3:0] slot,
                                                   input logic [2:0] row);
        logic [GLYPH_W*GLYPH_H-1:0] g;
        logic [GLYPH_W-1:0]         bits;
        unique case (slot)
            4'd0:    g = {5'h06, 5'h08, 5'h10, 5'h10, 5'h10, 5'h08, 5'h06};
            4'd1:    g = {5'h0C, 5'h02, 5'h01, 5'h01, 5'h01, 5'h02, 5'h0C};
            4'd2:    g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            4'd3:    g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            4'd4:    g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            4'd5:    g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            4'd6:    g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            4'd7:    g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            4'd8:    g = {5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h13, 5'h0D};
            4'd9:    g = {5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h13, 5'h0D};
            4'd10:   g = {5'h00, 5'h0D, 5'h13, 5'h11, 5'h0F, 5'h01, 5'h0E};
            4'd11:   g = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
            4'd12:   g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
            4'd13:   g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            4'd14:   g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            default: g = '0;
        endcase
        if (int'(row) < GLYPH_H) begin
            bits = g[(GLYPH_H - 1 - int'(row)) * GLYPH_W +: GLYPH_W];
        end else begin
            bits = '0;
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/scaled_bitmap_text_overlay.sv -----
// write item: result registered at dequeue, one write per cycle while m_tready is high
// pixel query: the back-end sequencer steps through dequeue, row/position compare,
//   column compare and glyph, and takes no new item until the result is registered
// a 2-entry queue separates input acceptance from the back end
// reset (aresetn low, synchronous): registers to defaults, line buffer blank, queue empty
`timescale 1ns / 1ps
`default_nettype none

module scaled_bitmap_text_overlay (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // char_index, char_code, pixel_x, pixel_y
    input  wire logic [0:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pixel_color
    output logic [0:0]       m_tuser,   // text_hit
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sbto_pkg::cfg_t       cfg;
    sbto_pkg::q_entry_t   push_entry;
    sbto_pkg::q_entry_t   q_data;
    sbto_pkg::back_stat_t stat;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;

    sbto_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbto_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_entry)
    );

    sbto_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    sbto_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .stat     (stat)
    );

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.q_pop |-> stat.q_valid)
        else $error("back end dequeued from an empty queue");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.out_load |-> (!m_tvalid || m_tready))
        else $error("result register loaded while a result still waits");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not empty after reset");

endmodule

`default_nettype wire

// ----- rtl/sbto_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbto_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sbto_pkg::cfg_t     cfg
);

    sbto_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_y         <= '0;
            cfg_reg.scale            <= 4'd1;
            cfg_reg.text_color       <= 16'hFFFF;
            cfg_reg.background_color <= '0;
            cfg_reg.text_length      <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                sbto_pkg::REG_ORIGIN_X:   cfg_reg.origin_x         <= pwdata[9:0];
                sbto_pkg::REG_ORIGIN_Y:   cfg_reg.origin_y         <= pwdata[9:0];
                sbto_pkg::REG_SCALE:      cfg_reg.scale            <= pwdata[3:0];
                sbto_pkg::REG_TEXT_COLOR: cfg_reg.text_color       <= pwdata[15:0];
                sbto_pkg::REG_BACK_COLOR: cfg_reg.background_color <= pwdata[15:0];
                sbto_pkg::REG_TEXT_LEN:   cfg_reg.text_length      <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            sbto_pkg::REG_ORIGIN_X:   prdata = {22'd0, cfg_reg.origin_x};
            sbto_pkg::REG_ORIGIN_Y:   prdata = {22'd0, cfg_reg.origin_y};
            sbto_pkg::REG_SCALE:      prdata = {28'd0, cfg_reg.scale};
            sbto_pkg::REG_TEXT_COLOR: prdata = {16'd0, cfg_reg.text_color};
            sbto_pkg::REG_BACK_COLOR: prdata = {16'd0, cfg_reg.background_color};
            sbto_pkg::REG_TEXT_LEN:   prdata = {27'd0, cfg_reg.text_length};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sbto_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbto_front (
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,   // char_index, char_code, pixel_x, pixel_y
    input  wire logic [0:0]       s_tuser,   // func
    input  wire sbto_pkg::cfg_t   cfg,
    input  wire logic             q_full,
    output logic                  push,
    output sbto_pkg::q_entry_t    entry
);

    logic [7:0]         px;
    logic [7:0]         py;
    logic signed [10:0] dx_s;
    logic signed [10:0] dy_s;
    logic               off_screen;

    assign px = s_tdata[19:12];
    assign py = s_tdata[27:20];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        dx_s = $signed({3'b000, px}) - $signed({cfg.origin_x[9], cfg.origin_x});
        dy_s = $signed({3'b000, py}) - $signed({cfg.origin_y[9], cfg.origin_y});
        off_screen = ({3'b000, px} >= 11'(sbto_pkg::SCREEN_WIDTH))
                  || ({3'b000, py} >= 11'(sbto_pkg::SCREEN_HEIGHT));

        entry.func       = s_tuser[0];
        entry.char_index = s_tdata[3:0];
        entry.char_code  = s_tdata[11:4];
        // queries that can never hit are marked here and report no hit
        entry.kill       = off_screen || dx_s[10] || dy_s[10] || (cfg.scale == 4'd0);
        entry.dx         = dx_s[sbto_pkg::COORD_W-1:0];
        entry.dy         = dy_s[sbto_pkg::COORD_W-1:0];
    end

endmodule

`default_nettype wire

// ----- rtl/sbto_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbto_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire sbto_pkg::q_entry_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output sbto_pkg::q_entry_t      data
);

    localparam int PTR_W = $clog2(sbto_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sbto_pkg::QUEUE_DEPTH + 1);

    sbto_pkg::q_entry_t mem [sbto_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = (count_reg == CNT_W'(sbto_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign data  = mem[rd_ptr_reg];

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sbto_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbto_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sbto_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    input  wire sbto_pkg::q_entry_t q_data,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,   // pixel_color
    output logic [0:0]              m_tuser,   // text_hit
    output sbto_pkg::back_stat_t    stat
);

    localparam int THR_W = sbto_pkg::THR_W;
    localparam int POS_W = sbto_pkg::POS_W;
    localparam int IDX_W = sbto_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEL,
        S_FIN
    } state_t;

    state_t                        state_reg;
    logic [7:0]                    line_chars_reg [sbto_pkg::MAX_CHARS];
    logic                          kill_reg;
    logic [sbto_pkg::COORD_W-1:0]  dx_reg;
    logic [sbto_pkg::COORD_W-1:0]  dy_reg;
    logic [2:0]                    gy_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [2:0]                    gx_reg;
    logic [7:0]                    code_reg;
    logic                          m_tvalid_reg;
    logic [15:0]                   m_color_reg;
    logic                          m_hit_reg;

    logic             out_free;
    logic             out_load;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_in_range;
    logic [THR_W-1:0] s_ext;
    logic [THR_W-1:0] step_w;
    logic [THR_W-1:0] dx_ext;
    logic [THR_W-1:0] dy_ext;
    logic [THR_W-1:0] rem;
    logic [2:0]       gy_next;
    logic [POS_W-1:0] pos_next;
    logic [2:0]       gx_next;
    logic             kill_div;
    int               len_i;
    logic [4:0]       row_bits;
    logic [2:0]       tap;
    logic             hit;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid
                   && ((q_data.func == sbto_pkg::FUNC_QUERY) || out_free);
    assign out_load = ((state_reg == S_IDLE) && q_pop && (q_data.func == sbto_pkg::FUNC_WRITE))
                   || ((state_reg == S_FIN) && out_free);

    assign wr_idx      = IDX_W'(q_data.char_index);
    assign wr_in_range = (int'(q_data.char_index) < sbto_pkg::MAX_CHARS);

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_color_reg;
    assign m_tuser[0] = m_hit_reg;

    assign stat.q_valid  = q_valid;
    assign stat.q_pop    = q_pop;
    assign stat.out_load = out_load;

    // row and character position by comparing against multiples of the scale
    always_comb begin
        s_ext  = THR_W'(cfg.scale);
        step_w = THR_W'(sbto_pkg::GLYPH_STEP) * s_ext;
        dx_ext = THR_W'(dx_reg);
        dy_ext = THR_W'(dy_reg);
        len_i  = (int'(cfg.text_length) > sbto_pkg::MAX_CHARS) ? sbto_pkg::MAX_CHARS
                                                               : int'(cfg.text_length);
        gy_next = '0;
        for (int k = 1; k <= sbto_pkg::GLYPH_H; k++) begin
            if (dy_ext >= THR_W'(k) * s_ext) begin
                gy_next = 3'(k);
            end
        end
        pos_next = '0;
        for (int k = 1; k <= sbto_pkg::MAX_CHARS; k++) begin
            if (dx_ext >= THR_W'(k) * step_w) begin
                pos_next = POS_W'(k);
            end
        end
        kill_div = (int'(gy_next) >= sbto_pkg::GLYPH_H) || (int'(pos_next) >= len_i);
    end

    // column inside the character step
    always_comb begin
        rem     = dx_ext - THR_W'(pos_reg) * step_w;
        gx_next = '0;
        for (int k = 1; k <= sbto_pkg::GLYPH_W; k++) begin
            if (rem >= THR_W'(k) * s_ext) begin
                gx_next = 3'(k);
            end
        end
    end

    always_comb begin
        row_bits = sbto_pkg::font_row(sbto_pkg::glyph_slot(code_reg), gy_reg);
        tap      = (int'(gx_reg) < sbto_pkg::GLYPH_W) ? 3'(sbto_pkg::GLYPH_W - 1) - gx_reg
                                                     : 3'd0;
        // spacing column gives gx equal to the glyph width
        hit      = !kill_reg && (int'(gx_reg) < sbto_pkg::GLYPH_W) && row_bits[tap];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < sbto_pkg::MAX_CHARS; i++) begin
                line_chars_reg[i] <= '0;
            end
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        if (q_data.func == sbto_pkg::FUNC_WRITE) begin
                            if (wr_in_range) begin
                                line_chars_reg[wr_idx] <= q_data.char_code;
                            end
                            m_tvalid_reg <= 1'b1;
                            m_color_reg  <= '0;
                            m_hit_reg    <= 1'b0;
                        end else begin
                            kill_reg  <= q_data.kill;
                            dx_reg    <= q_data.dx;
                            dy_reg    <= q_data.dy;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    gy_reg    <= gy_next;
                    pos_reg   <= pos_next;
                    kill_reg  <= kill_reg || kill_div;
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    gx_reg    <= gx_next;
                    code_reg  <= line_chars_reg[pos_reg[IDX_W-1:0]];
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_color_reg  <= hit ? cfg.text_color : cfg.background_color;
                        m_hit_reg    <= hit;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
